[design/assert_macros.svh]
// Assertion macros shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/fmeg_pkg.sv]
// Package: shared types, constants and small functions of the envelope generator.
package fmeg_pkg;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	// envelope stages
	localparam logic [1:0] ST_ATTACK  = 2'd0;
	localparam logic [1:0] ST_DECAY   = 2'd1;
	localparam logic [1:0] ST_RELEASE = 2'd2;
	localparam logic [1:0] ST_DAMPING = 2'd3;

	// fixed rates
	localparam logic [3:0] RATE_PERCUSSIVE = 4'd7;
	localparam logic [3:0] RATE_SUSTAINED  = 4'd5;
	localparam logic [3:0] RATE_DAMPING    = 4'd12;
	localparam logic [3:0] RATE_MAX        = 4'd15;

	localparam logic [4:0] ADVANCE_POSITION = 5'd16;

	// attenuation constants
	localparam logic [6:0] ATT_MAX     = 7'h7f;
	localparam logic [6:0] DAMP_FLOOR  = 7'h7c;
	localparam logic [6:0] MASK_STEP1  = 7'b1111101;
	localparam logic [6:0] MASK_STEP2  = 7'b1111110;

	// rate + trailing-zero sums that fire the counter tap
	localparam logic [4:0] TAP_BASE = 5'd12;
	localparam logic [4:0] TAP_ODD  = 5'd13;
	localparam logic [4:0] TAP_EVEN = 5'd14;

	typedef struct packed {
		logic [4:0] position;
		logic       in_range;
		logic       mod_hold;      // sustained modulator: ignores key-off
		logic [3:0] atk_rate;
		logic [3:0] dcy_rate;
		logic [3:0] rel_rate;      // rate used in the release stage
		logic [3:0] damping_rate;  // rate used in the damping stage
		logic [3:0] sus_level;
		logic [1:0] ks_high;
		logic [1:0] ks_low;
		logic       key_on;
		logic       restart_request;
	} fmeg_entry_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} fmeg_qstat_t;

	// per key-scale low bits: which timer phases add the extra step
	function automatic logic [3:0] step_pattern(input logic [1:0] rlow);
		logic [3:0] p;
		begin
			case (rlow)
				2'd0:    p = 4'h0;
				2'd1:    p = 4'h1;
				2'd2:    p = 4'h5;
				2'd3:    p = 4'h7;
				default: p = 4'h0;
			endcase
			return p;
		end
	endfunction

	// modulator when ((pos + 1) / 3) is even; x*43 >> 7 is x/3 for x < 64
	function automatic logic is_modulator(input logic [4:0] pos);
		logic [5:0]  p1;
		logic [11:0] prod;
		begin
			p1   = {1'b0, pos} + 6'd1;
			prod = {6'd0, p1} * 12'd43;
			return !prod[7];
		end
	endfunction

endpackage

[design/fmeg_front.sv]
// Front: classifies an incoming slot request into a queue entry.
module fmeg_front #(
	parameter int SLOT_COUNT = 18
) (
	input  logic [4:0]           slot_position,
	input  logic [2:0]           octave,
	input  logic                 fnum_msb,
	input  logic [3:0]           atk_rate,
	input  logic [3:0]           dcy_rate,
	input  logic [3:0]           rel_rate,
	input  logic [3:0]           sus_level,
	input  logic                 rate_key_scaling,
	input  logic                 sustained_tone,
	input  logic                 key_on,
	input  logic                 channel_sustain,
	input  logic                 restart_request,
	output fmeg_pkg::fmeg_entry_t entry
);

	logic [3:0] ksr;
	logic [3:0] damp_rate;

	always_comb begin
		ksr = rate_key_scaling ? {octave, fnum_msb} : {2'b00, octave[2:1]};
		if (key_on) begin
			damp_rate = fmeg_pkg::RATE_DAMPING;
		end else if (channel_sustain) begin
			damp_rate = fmeg_pkg::RATE_SUSTAINED;
		end else if (!sustained_tone) begin
			damp_rate = fmeg_pkg::RATE_PERCUSSIVE;
		end else begin
			damp_rate = rel_rate;
		end
	end

	always_comb begin
		entry.position        = slot_position;
		entry.in_range        = {1'b0, slot_position} < 6'(SLOT_COUNT);
		entry.mod_hold        = fmeg_pkg::is_modulator(slot_position) && sustained_tone;
		entry.atk_rate        = atk_rate;
		entry.dcy_rate        = dcy_rate;
		entry.rel_rate        = sustained_tone ? 4'd0 : rel_rate;
		entry.damping_rate    = damp_rate;
		entry.sus_level       = sus_level;
		entry.ks_high         = ksr[3:2];
		entry.ks_low          = ksr[1:0];
		entry.key_on          = key_on;
		entry.restart_request = restart_request;
	end

endmodule

[design/fmeg_queue.sv]
// Queue: short request FIFO between front and back.
module fmeg_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fmeg_pkg::fmeg_entry_t push_entry,
	input  logic                  pop,
	output fmeg_pkg::fmeg_entry_t head,
	output fmeg_pkg::fmeg_qstat_t status
);

	fmeg_pkg::fmeg_entry_t               mem_q [fmeg_pkg::QUEUE_DEPTH];
	logic [fmeg_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [fmeg_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [fmeg_pkg::QCNT_W-1:0]         count_q;
	logic                                do_push;
	logic                                do_pop;

	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == fmeg_pkg::QCNT_W'(fmeg_pkg::QUEUE_DEPTH));
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/fmeg_back.sv]
// Back: per-slot envelope update, shared counters and the result register.
module fmeg_back #(
	parameter int SLOT_COUNT = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  entry_valid,
	input  fmeg_pkg::fmeg_entry_t entry,
	output logic                  entry_ready,
	output logic [6:0]            attenuation,
	output logic [1:0]            stage,
	output logic                  out_valid,
	input  logic                  out_ready
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	logic [6:0]  att_q   [SLOT_COUNT];
	logic [1:0]  stg_q   [SLOT_COUNT];
	logic        en_q    [SLOT_COUNT];

	logic [1:0]  sub_q;
	logic [12:0] timer_q;
	logic [3:0]  tz_q;

	logic [6:0]  att_out_q;
	logic [1:0]  stg_out_q;
	logic        out_valid_q;

	logic             fire;
	logic [IDX_W-1:0] idx;

	// update datapath
	logic [6:0]  cur_v;
	logic [1:0]  cur_st;
	logic        cur_en;
	logic [3:0]  rbase;
	logic [4:0]  rsum;
	logic [3:0]  rh;
	logic [4:0]  zsum;
	logic        tap;
	logic [3:0]  pat;
	logic        tab;
	logic        mzero;
	logic        meven;
	logic [6:0]  i1, i2, i3, i4, inc, vsum;
	logic [6:0]  nv;
	logic [1:0]  nst;
	logic        nen;
	logic [6:0]  res_v;
	logic [1:0]  res_st;

	// counters
	logic        advance;
	logic [12:0] timer_n;
	logic [3:0]  tz_n;

	assign entry_ready = !out_valid_q || out_ready;
	assign fire        = entry_valid && entry_ready;
	assign idx         = entry.position[IDX_W-1:0];
	assign out_valid   = out_valid_q;
	assign attenuation = att_out_q;
	assign stage       = stg_out_q;

	always_comb begin
		if (entry.in_range) begin
			cur_v  = att_q[idx];
			cur_st = stg_q[idx];
			cur_en = en_q[idx];
		end else begin
			cur_v  = fmeg_pkg::ATT_MAX;
			cur_st = fmeg_pkg::ST_RELEASE;
			cur_en = 1'b0;
		end

		case (cur_st)
			fmeg_pkg::ST_ATTACK:  rbase = entry.atk_rate;
			fmeg_pkg::ST_DECAY:   rbase = entry.dcy_rate;
			fmeg_pkg::ST_RELEASE: rbase = entry.rel_rate;
			default:              rbase = entry.damping_rate;
		endcase
		rsum = {1'b0, rbase} + {3'b000, entry.ks_high};
		rh   = rsum[4] ? fmeg_pkg::RATE_MAX : rsum[3:0];

		// counter tap: rate plus trailing zeros of the timer
		zsum = {1'b0, rh} + {1'b0, tz_q};
		tap  = 1'b0;
		if (rh != 4'd0 && rh < fmeg_pkg::RATE_DAMPING) begin
			if (zsum == fmeg_pkg::TAP_BASE) begin
				tap = 1'b1;
			end else if (zsum == fmeg_pkg::TAP_ODD && entry.ks_low[1]) begin
				tap = 1'b1;
			end else if (zsum == fmeg_pkg::TAP_EVEN && entry.ks_low[0]) begin
				tap = 1'b1;
			end
		end

		pat   = fmeg_pkg::step_pattern(entry.ks_low);
		tab   = pat[timer_q[1:0]];
		mzero = (sub_q == 2'd0);
		meven = !sub_q[0];

		if (cur_st == fmeg_pkg::ST_ATTACK) begin
			i1 = cur_v >> 1;
			i2 = cur_v >> 2;
			i3 = cur_v >> 3;
			i4 = cur_v >> 4;
		end else begin
			i1 = fmeg_pkg::ATT_MAX;
			i2 = fmeg_pkg::ATT_MAX;
			i3 = fmeg_pkg::ATT_MAX;
			i4 = fmeg_pkg::ATT_MAX;
		end
		if (cur_en) begin
			i1 = i1 & fmeg_pkg::MASK_STEP1;
			i2 = i2 & fmeg_pkg::MASK_STEP2;
		end

		inc = fmeg_pkg::ATT_MAX;
		if (tap || (!tab && rh == 4'd12)) begin
			inc = inc & i4;
		end
		if ((!tab && rh == 4'd13) || (tab && rh == 4'd12)) begin
			inc = inc & i3;
		end
		if ((tap && mzero && cur_en)
			|| (rh == 4'd14 && !tab)
			|| (rh == 4'd13 && tab)
			|| (rh == 4'd13 && !tab && meven && cur_en)
			|| (rh == 4'd12 && !tab && mzero && cur_en)
			|| (rh == 4'd12 && tab && meven && cur_en)) begin
			inc = inc & i2;
		end
		if (rh == fmeg_pkg::RATE_MAX || (rh == 4'd14 && tab)) begin
			inc = inc & i1;
		end

		vsum = (cur_v ^ fmeg_pkg::ATT_MAX) + inc + 7'd1;
		nv   = ~vsum;
		nst  = cur_st;
		nen  = cur_en;

		// stage transitions
		if (entry.restart_request) begin
			nen = 1'b1;
			nst = fmeg_pkg::ST_DAMPING;
		end
		if (nst == fmeg_pkg::ST_ATTACK && rh == fmeg_pkg::RATE_MAX) begin
			nv  = 7'd0;
			nst = fmeg_pkg::ST_DECAY;
		end
		if (nst == fmeg_pkg::ST_ATTACK && nv == 7'd0) begin
			nst = fmeg_pkg::ST_DECAY;
		end
		if (nst == fmeg_pkg::ST_DAMPING && nv >= fmeg_pkg::DAMP_FLOOR) begin
			nst = fmeg_pkg::ST_ATTACK;
		end
		if (nst == fmeg_pkg::ST_DECAY && nv[6:3] == entry.sus_level) begin
			nst = fmeg_pkg::ST_RELEASE;
		end
		if (!entry.key_on && !entry.mod_hold) begin
			nst = fmeg_pkg::ST_DAMPING;
			nen = 1'b1;
		end
		if ((nst == fmeg_pkg::ST_RELEASE || nst == fmeg_pkg::ST_DAMPING)
			&& nv >= fmeg_pkg::DAMP_FLOOR) begin
			nen = 1'b0;
		end

		res_v  = entry.in_range ? nv  : fmeg_pkg::ATT_MAX;
		res_st = entry.in_range ? nst : fmeg_pkg::ST_RELEASE;
	end

	// shared counter advance and the new timer's trailing-zero count plus one
	always_comb begin
		advance = fire && (entry.position == fmeg_pkg::ADVANCE_POSITION);
		timer_n = (sub_q == 2'd3) ? timer_q + 13'd1 : timer_q;
		tz_n    = 4'd0;
		for (int b = 12; b >= 0; b--) begin
			if (timer_n[b]) begin
				tz_n = 4'(b + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				att_q[s] <= fmeg_pkg::ATT_MAX;
				stg_q[s] <= fmeg_pkg::ST_RELEASE;
				en_q[s]  <= 1'b0;
			end
		end else if (fire && entry.in_range) begin
			att_q[idx] <= nv;
			stg_q[idx] <= nst;
			en_q[idx]  <= nen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= 2'd0;
			timer_q     <= 13'd0;
			tz_q        <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				sub_q   <= sub_q + 2'd1;
				timer_q <= timer_n;
				tz_q    <= tz_n;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			att_out_q <= res_v;
			stg_out_q <= res_st;
		end
	end

endmodule

[design/fm_envelope_generator.sv]
// Top level: FM envelope generator, front classifier, request queue and update back end.
//
// Use: one request per slot step on the in_valid/in_ready channel, carrying the
// slot's schedule position, key-scale inputs, patch rates, sustain level, key-on
// and restart flag. One result (attenuation, stage) per request comes back on the
// out_valid/out_ready channel, in request order.
// Path: an accepted request is written into the two-entry queue, then the back
// end pops it and loads the result register, which raises out_valid; a stalled
// result register holds the request in the queue.
// Throughput: one request per cycle while the receiver takes every result; the
// back end reads, updates and writes the slot's state when it takes a request,
// so consecutive requests to the same slot chain with no bubble.
// in_ready depends only on queue occupancy: it drops when both entries are held.
// When the receiver stalls, the result register holds, the back end stops
// popping, and the queue absorbs up to two more requests before in_ready falls.
// Reset (arst_n low, asynchronous): every slot goes to attenuation 127, release
// stage, disabled; the shared sub-counter, envelope timer and trailing-zero count
// clear; the queue empties and out_valid drops. No clearing pass is needed.
// Shared counters advance when the request at position 16 is processed.
`include "assert_macros.svh"

module fm_envelope_generator #(
	parameter int SLOT_COUNT = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [4:0] slot_position,
	input  logic [2:0] octave,
	input  logic       fnum_msb,
	input  logic [3:0] atk_rate,
	input  logic [3:0] dcy_rate,
	input  logic [3:0] rel_rate,
	input  logic [3:0] sus_level,
	input  logic       rate_key_scaling,
	input  logic       sustained_tone,
	input  logic       key_on,
	input  logic       channel_sustain,
	input  logic       restart_request,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] attenuation,
	output logic [1:0] stage
);

	fmeg_pkg::fmeg_entry_t front_entry;
	fmeg_pkg::fmeg_entry_t head_entry;
	fmeg_pkg::fmeg_qstat_t q_status;
	logic                  push;
	logic                  pop;
	logic                  back_ready;

	// front: classify and hand to the queue
	fmeg_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.slot_position   (slot_position),
		.octave          (octave),
		.fnum_msb        (fnum_msb),
		.atk_rate        (atk_rate),
		.dcy_rate        (dcy_rate),
		.rel_rate        (rel_rate),
		.sus_level       (sus_level),
		.rate_key_scaling(rate_key_scaling),
		.sustained_tone  (sustained_tone),
		.key_on          (key_on),
		.channel_sustain (channel_sustain),
		.restart_request (restart_request),
		.entry           (front_entry)
	);

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready;
	assign pop      = !q_status.empty && back_ready;

	fmeg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(front_entry),
		.pop       (pop),
		.head      (head_entry),
		.status    (q_status)
	);

	// back: slot state update, shared counters, result register
	fmeg_back #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry_valid(!q_status.empty),
		.entry      (head_entry),
		.entry_ready(back_ready),
		.attenuation(attenuation),
		.stage      (stage),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

	// back end must hold while the receiver stalls a result
	`ASSERT_IMPL(a_no_pop_on_stall, out_valid && !out_ready, !pop,
		"request popped while result stalled")
	// a popped request always yields a result next cycle
	`ASSERT_NEXT(a_pop_gives_result, pop, out_valid,
		"popped request produced no result")
	// queue never reports more entries than it holds
	`ASSERT_IMPL(a_queue_bound, 1'b1,
		q_status.count <= fmeg_pkg::QCNT_W'(fmeg_pkg::QUEUE_DEPTH),
		"queue occupancy beyond depth")
	// a push into an empty queue leaves it non-empty next cycle
	`ASSERT_NEXT(a_empty_push_visible, push && q_status.empty && !pop, !q_status.empty,
		"pushed request lost")

endmodule

[sim/tb.sv]
// Testbench for fm_envelope_generator: directed table plus scheduled random requests vs. predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 8;
	localparam int SLOTS       = 18;
	localparam int RAND_ITEMS  = 1700;
	localparam int STUCK_LIMIT = 2000;  // cycles with no transfer on either side
	localparam int TAIL_CYCLES = 8;     // plenty of margin after the final drain
	localparam int N_DIRECTED  = 23;

	// One slot update request, fields in port order.
	typedef struct packed {
		logic [4:0] pos;
		logic [2:0] oct;
		logic       fmsb;
		logic [3:0] ar, dr, rr, sl;
		logic       rks;
		logic       sus_tone;
		logic       key;
		logic       ch_sus;
		logic       restart;
	} env_req_t;

	typedef struct packed {
		logic [6:0] att;
		logic [1:0] st;
	} env_out_t;

	// Directed row: request, plus a typed-in result where it is obvious.
	typedef struct packed {
		env_req_t   req;
		logic       fixed;
		logic [6:0] att;
		logic [1:0] st;
	} dir_row_t;

	// pos oct fmsb ar dr rr sl rks sus key chs rst
	localparam dir_row_t DIRECTED [N_DIRECTED] = '{
		// out-of-range position, every field at its top value
		'{'{31, 7, 1, 15, 15, 15, 15, 1, 1, 1, 1, 1}, 1, 127, fmeg_pkg::ST_RELEASE},
		// fresh slot, sustained patch in release: rate 0, nothing moves
		'{'{ 0, 0, 0,  0,  0,  0,  0, 0, 1, 1, 0, 0}, 1, 127, fmeg_pkg::ST_RELEASE},
		// restart from silence goes straight through damping to attack
		'{'{ 0, 0, 0, 15,  0,  0,  0, 0, 1, 1, 0, 1}, 1, 127, fmeg_pkg::ST_ATTACK},
		// attack rate 15 jumps to 0, sustain level 0 ends decay at once
		'{'{ 0, 0, 0, 15,  0,  0,  0, 0, 1, 1, 0, 0}, 1,   0, fmeg_pkg::ST_RELEASE},
		'{'{ 1, 0, 0, 15, 15, 15, 15, 0, 1, 1, 0, 1}, 1, 127, fmeg_pkg::ST_ATTACK},
		'{'{ 1, 0, 0, 15, 15, 15, 15, 0, 1, 1, 0, 0}, 1,   0, fmeg_pkg::ST_DECAY},
		// decay at full rate with full key scaling
		'{'{ 1, 7, 1, 15, 15, 15, 15, 1, 1, 1, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		// restart on a loud slot lands in damping, then damping with key held
		'{'{ 1, 3, 0,  9,  4, 11,  6, 1, 1, 1, 0, 1}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{ 1, 3, 0,  9,  4, 11,  6, 1, 1, 1, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		// key-off: percussive, channel sustain, sustained modulator held
		'{'{ 1, 5, 1,  9,  4, 11,  6, 0, 0, 0, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{ 1, 5, 1,  9,  4, 11,  6, 0, 0, 0, 1, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{ 1, 5, 1,  9,  4, 11,  6, 0, 1, 0, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{ 0, 2, 1,  3,  8, 10, 15, 1, 1, 0, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		// carrier: restart, then key-off is not held even when sustained
		'{'{ 2, 0, 0, 15,  0,  0,  0, 0, 1, 1, 0, 1}, 1, 127, fmeg_pkg::ST_ATTACK},
		'{'{ 2, 0, 0, 15,  0,  0,  0, 0, 1, 0, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		// counter advance position, rates around the tap window
		'{'{16, 7, 1, 12, 12, 12,  8, 1, 0, 1, 0, 1}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{16, 4, 0, 13, 13, 13,  8, 1, 0, 1, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{16, 6, 1, 14, 14, 14,  8, 1, 0, 1, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{16, 1, 1,  0,  0,  0,  0, 0, 0, 1, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		// last in-range slot, attack rate 0 lifted only by key scaling
		'{'{17, 7, 1,  0,  0, 15, 15, 1, 0, 1, 0, 1}, 0,   0, fmeg_pkg::ST_DECAY},
		'{'{17, 7, 1,  0,  0, 15, 15, 1, 0, 1, 0, 0}, 0,   0, fmeg_pkg::ST_DECAY},
		// first out-of-range position
		'{'{18, 0, 0,  0,  0,  0,  0, 0, 0, 0, 0, 0}, 1, 127, fmeg_pkg::ST_RELEASE},
		'{'{ 5, 6, 0, 11,  7,  3,  2, 0, 0, 1, 1, 1}, 0,   0, fmeg_pkg::ST_DECAY}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [4:0] slot_position = '0;
	logic [2:0] octave = '0;
	logic       fnum_msb = 1'b0;
	logic [3:0] atk_rate = '0;
	logic [3:0] dcy_rate = '0;
	logic [3:0] rel_rate = '0;
	logic [3:0] sus_level = '0;
	logic       rate_key_scaling = 1'b0;
	logic       sustained_tone = 1'b0;
	logic       key_on = 1'b0;
	logic       channel_sustain = 1'b0;
	logic       restart_request = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b1;
	logic [6:0] attenuation;
	logic [1:0] stage;

	// Sideband that travels with the request: typed-in result, if any.
	logic       row_fixed = 1'b0;
	env_out_t   row_result = '0;

	// Predictor state: per-slot envelope and the shared counters.
	logic [6:0]  env_level  [SLOTS];
	logic [1:0]  env_phase  [SLOTS];
	logic        env_active [SLOTS];
	logic [1:0]  eg_subcount;
	logic [12:0] eg_timer;
	logic [3:0]  eg_tz;

	env_out_t pending_env[$];  // expected results, oldest first
	int       mismatch_count = 0;
	int       stuck_cycles = 0;
	int       send_idle_pct = 34;
	int       recv_stall_pct = 48;

	fm_envelope_generator #(
		.SLOT_COUNT(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.slot_position(slot_position),
		.octave(octave),
		.fnum_msb(fnum_msb),
		.atk_rate(atk_rate),
		.dcy_rate(dcy_rate),
		.rel_rate(rel_rate),
		.sus_level(sus_level),
		.rate_key_scaling(rate_key_scaling),
		.sustained_tone(sustained_tone),
		.key_on(key_on),
		.channel_sustain(channel_sustain),
		.restart_request(restart_request),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.attenuation(attenuation),
		.stage(stage)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Applies one request to the predictor state and returns the new envelope.
	function automatic env_out_t update_envelope(input env_req_t r);
		env_out_t   res;
		logic [6:0] v, inc, i1, i2, i3, i4;
		logic [1:0] st, rlow;
		logic [3:0] ksr, base;
		logic [4:0] rate, rsum;
		logic [3:0] pattern;
		logic [12:0] t;
		logic       en, tick, tab, mzero, meven, held;
		res = '{att: fmeg_pkg::ATT_MAX, st: fmeg_pkg::ST_RELEASE};
		if (r.pos < SLOTS) begin
			v  = env_level[r.pos];
			st = env_phase[r.pos];
			en = env_active[r.pos];

			ksr = {r.oct, r.fmsb};
			if (!r.rks)
				ksr = ksr >> 2;
			rlow = ksr[1:0];

			// base rate picked by stage; damping depends on key and sustain
			case (st)
				fmeg_pkg::ST_ATTACK:  base = r.ar;
				fmeg_pkg::ST_DECAY:   base = r.dr;
				fmeg_pkg::ST_RELEASE: base = r.sus_tone ? 4'd0 : r.rr;
				default: begin
					if (r.key)
						base = fmeg_pkg::RATE_DAMPING;
					else if (r.ch_sus)
						base = fmeg_pkg::RATE_SUSTAINED;
					else if (!r.sus_tone)
						base = fmeg_pkg::RATE_PERCUSSIVE;
					else
						base = r.rr;
				end
			endcase
			rate = {1'b0, base} + ksr[3:2];
			if (rate > fmeg_pkg::RATE_MAX)
				rate = fmeg_pkg::RATE_MAX;

			// slow rates step when rate + trailing zeros hits the tap window
			tick = 1'b0;
			if (rate != 0 && rate < 12) begin
				rsum = rate + eg_tz;
				tick = (rsum == fmeg_pkg::TAP_BASE) || (rsum == fmeg_pkg::TAP_ODD && rlow[1])
					|| (rsum == fmeg_pkg::TAP_EVEN && rlow[0]);
			end

			case (rlow)
				2'd0:    pattern = 4'h0;
				2'd1:    pattern = 4'h1;
				2'd2:    pattern = 4'h5;
				default: pattern = 4'h7;
			endcase
			tab   = pattern[eg_timer[1:0]];
			mzero = (eg_subcount == 0);
			meven = !eg_subcount[0];

			// attack steps scale with the current level, the others do not depend on it
			if (st == fmeg_pkg::ST_ATTACK) begin
				i1 = v >> 1;
				i2 = v >> 2;
				i3 = v >> 3;
				i4 = v >> 4;
			end else begin
				i1 = fmeg_pkg::ATT_MAX;
				i2 = fmeg_pkg::ATT_MAX;
				i3 = fmeg_pkg::ATT_MAX;
				i4 = fmeg_pkg::ATT_MAX;
			end
			if (en) begin
				i1 &= fmeg_pkg::MASK_STEP1;
				i2 &= fmeg_pkg::MASK_STEP2;
			end

			inc = fmeg_pkg::ATT_MAX;
			if (tick || (!tab && rate == 12))
				inc &= i4;
			if ((!tab && rate == 13) || (tab && rate == 12))
				inc &= i3;
			if ((tick && mzero && en) || (rate == 14 && !tab) || (rate == 13 && tab)
					|| (rate == 13 && !tab && meven && en)
					|| (rate == 12 && !tab && mzero && en)
					|| (rate == 12 && tab && meven && en))
				inc &= i2;
			if (rate == 15 || (rate == 14 && tab))
				inc &= i1;

			// ones-complement add: inc all ones leaves the level alone
			i1 = ~v + inc + 7'd1;
			v  = ~i1;

			held = ((((int'(r.pos) + 1) / 3) % 2) == 0) && r.sus_tone;
			if (r.restart) begin
				en = 1'b1;
				st = fmeg_pkg::ST_DAMPING;
			end
			if (st == fmeg_pkg::ST_ATTACK && rate == fmeg_pkg::RATE_MAX) begin
				v  = '0;
				st = fmeg_pkg::ST_DECAY;
			end
			if (st == fmeg_pkg::ST_ATTACK && v == 0)
				st = fmeg_pkg::ST_DECAY;
			if (st == fmeg_pkg::ST_DAMPING && v >= fmeg_pkg::DAMP_FLOOR)
				st = fmeg_pkg::ST_ATTACK;
			if (st == fmeg_pkg::ST_DECAY && v[6:3] == r.sl)
				st = fmeg_pkg::ST_RELEASE;
			if (!r.key && !held) begin
				st = fmeg_pkg::ST_DAMPING;
				en = 1'b1;
			end
			if ((st == fmeg_pkg::ST_RELEASE || st == fmeg_pkg::ST_DAMPING)
					&& v >= fmeg_pkg::DAMP_FLOOR)
				en = 1'b0;

			env_level[r.pos]  = v;
			env_phase[r.pos]  = st;
			env_active[r.pos] = en;
			res = '{att: v, st: st};
		end

		// shared counters step after the advance position, in range or not
		if (r.pos == fmeg_pkg::ADVANCE_POSITION) begin
			eg_subcount = eg_subcount + 2'd1;
			if (eg_subcount == 0)
				eg_timer = eg_timer + 13'd1;
			if (eg_timer == 0) begin
				eg_tz = '0;
			end else begin
				eg_tz = 4'd1;
				t = eg_timer;
				while (!t[0]) begin
					eg_tz++;
					t = t >> 1;
				end
			end
		end
		return res;
	endfunction

	// Random patch; rates lean high so envelopes actually move in a short run.
	function automatic env_req_t random_patch();
		env_req_t p;
		p          = '0;
		p.oct      = 3'($urandom_range(7));
		p.fmsb     = 1'($urandom_range(1));
		p.ar       = ($urandom_range(99) < 60) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(15));
		p.dr       = ($urandom_range(99) < 50) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(15));
		p.rr       = ($urandom_range(99) < 50) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(15));
		p.sl       = 4'($urandom_range(15));
		p.rks      = 1'($urandom_range(1));
		p.sus_tone = 1'($urandom_range(1));
		p.ch_sus   = ($urandom_range(99) < 25);
		return p;
	endfunction

	// Drive one request and hold it until the block takes it.
	task automatic send_request(input env_req_t r, input logic fixed, input env_out_t res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		slot_position    <= r.pos;
		octave           <= r.oct;
		fnum_msb         <= r.fmsb;
		atk_rate         <= r.ar;
		dcy_rate         <= r.dr;
		rel_rate         <= r.rr;
		sus_level        <= r.sl;
		rate_key_scaling <= r.rks;
		sustained_tone   <= r.sus_tone;
		key_on           <= r.key;
		channel_sustain  <= r.ch_sus;
		restart_request  <= r.restart;
		row_fixed        <= fixed;
		row_result       <= res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stop sending until every outstanding result is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_env.size() != 0)
			@(posedge clk);
	endtask

	// Predict on accepted requests, check accepted results, random out_ready,
	// watchdog. Everything samples pre-edge values, so ordering is fixed.
	always @(posedge clk) begin
		env_req_t seen;
		env_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen = {slot_position, octave, fnum_msb, atk_rate, dcy_rate,
					rel_rate, sus_level, rate_key_scaling, sustained_tone,
					key_on, channel_sustain, restart_request};
				want = update_envelope(seen);
				pending_env.push_back(row_fixed ? row_result : want);
			end
			if (out_valid && out_ready) begin
				if (pending_env.size() == 0) begin
					report_mismatch($sformatf("result att=%0d stage=%0d with nothing pending",
						attenuation, stage));
				end else begin
					want = pending_env.pop_front();
					if (attenuation !== want.att)
						report_mismatch($sformatf("attenuation got %0d want %0d",
							attenuation, want.att));
					if (stage !== want.st)
						report_mismatch($sformatf("stage got %0d want %0d", stage, want.st));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL fm_envelope_generator");
				$finish;
			end
		end
	end

	initial begin
		env_req_t    r;
		env_req_t    patch [32];
		logic        key_now [32];
		logic        key_last [32];
		logic [31:0] raw;
		logic [4:0]  pos;
		int          n, sched, ff_left;
		logic        noise;

		// predictor reset state
		for (n = 0; n < SLOTS; n++) begin
			env_level[n]  = fmeg_pkg::ATT_MAX;
			env_phase[n]  = fmeg_pkg::ST_RELEASE;
			env_active[n] = 1'b0;
		end
		eg_subcount = '0;
		eg_timer    = '0;
		eg_tz       = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, first idling mix
		for (n = 0; n < N_DIRECTED; n++)
			send_request(DIRECTED[n].req, DIRECTED[n].fixed,
				'{att: DIRECTED[n].att, st: DIRECTED[n].st});

		for (n = 0; n < 32; n++) begin
			patch[n]    = random_patch();
			key_now[n]  = 1'b0;
			key_last[n] = 1'b0;
		end
		sched   = 0;
		ff_left = 0;

		// Random part: mostly the normal slot schedule with per-slot patches and
		// key on/off history; some noise requests at any position; now and then a
		// run of advance-position requests to push the envelope timer along.
		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				drain_results();
				send_idle_pct  = 48;
				recv_stall_pct = 34;
			end else if (n == 2 * RAND_ITEMS / 3) begin
				drain_results();
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end

			noise = 1'b0;
			if (ff_left != 0) begin
				pos = fmeg_pkg::ADVANCE_POSITION;
				ff_left--;
			end else begin
				if ($urandom_range(999) < 4)
					ff_left = 40;
				noise = ($urandom_range(99) < 8);
				if (noise) begin
					pos = 5'($urandom_range(31));
				end else begin
					pos   = 5'(sched);
					sched = (sched == SLOTS - 1) ? 0 : sched + 1;
				end
			end

			if (noise) begin
				raw = $urandom;
				r   = raw[29:0];
				r.pos = pos;
			end else begin
				if ($urandom_range(99) < 4)
					patch[pos] = random_patch();
				if ($urandom_range(99) < 6)
					key_now[pos] = !key_now[pos];
				r         = patch[pos];
				r.pos     = pos;
				r.key     = key_now[pos];
				r.restart = key_now[pos] && !key_last[pos];
				key_last[pos] = key_now[pos];
			end
			send_request(r, 1'b0, '0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS fm_envelope_generator");
		else
			$display("FAIL fm_envelope_generator");
		$finish;
	end

endmodule
